### design/cdc_pkg.sv
`timescale 1ns / 1ps

package cdc_pkg;

  // field widths
  localparam int unsigned YearW  = 7;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 16;
  localparam int unsigned WdayW  = 3;

  // months that matter for leap days and summer time
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthOct = 4'd10;

  // days before the first of the given month, whole year above december
  function automatic logic [8:0] cum_days(input logic [MonthW-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      4'd12:      r = 9'd334;
      default:    r = 9'd365;
    endcase
    return r;
  endfunction

  // modulo 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [16:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
       + 6'(v[14:12]) + 6'(v[16:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    return s3[2:0];
  endfunction

endpackage

### design/cdc_day_count.sv
`timescale 1ns / 1ps

module cdc_day_count
  import cdc_pkg::*;
(
  input  logic [YearW-1:0]  year_offset_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [DayW-1:0]   day_i,
  output logic [CountW-1:0] day_count_o,
  output logic [WdayW-1:0]  weekday_o
);

  logic [7:0]        y_plus3;
  logic [5:0]        leap_days;
  logic              leap_now;
  logic [15:0]       year_days;
  logic [CountW-1:0] sum;
  logic [16:0]       wd_arg;

  assign y_plus3   = 8'(year_offset_i) + 8'd3;
  assign leap_days = y_plus3[7:2];
  assign leap_now  = (month_i > MonthFeb) && (year_offset_i[1:0] == 2'b00);
  // 365 * y as shifts: 256 + 64 + 32 + 8 + 4 + 1
  assign year_days = (16'(year_offset_i) << 8) + (16'(year_offset_i) << 6)
                   + (16'(year_offset_i) << 5) + (16'(year_offset_i) << 3)
                   + (16'(year_offset_i) << 2) + 16'(year_offset_i);

  assign sum = 16'(day_i) + 16'(cum_days(month_i)) + 16'(leap_now)
             + year_days + 16'(leap_days);

  // day zero of jan 2000 wraps to all ones
  assign day_count_o = sum - 16'd1;

  // 2000-01-01 is a saturday
  assign wd_arg    = 17'(day_count_o) + 17'd5;
  assign weekday_o = mod7(wd_arg);

endmodule

### design/cdc_dst.sv
`timescale 1ns / 1ps

module cdc_dst
  import cdc_pkg::*;
(
  input  logic [YearW-1:0]  year_offset_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [DayW-1:0]   day_i,
  output logic              summer_time_o
);

  localparam logic [8:0] MarShift = 9'd5;
  localparam logic [8:0] OctShift = 9'd2;

  logic [9:0]      y5;
  logic [8:0]      k_base;
  logic [8:0]      k_mar;
  logic [8:0]      k_oct;
  logic [DayW-1:0] last_sun_mar;
  logic [DayW-1:0] last_sun_oct;

  assign y5     = (10'(year_offset_i) << 2) + 10'(year_offset_i);
  // century term is 0 or 1 in the 7-bit range, the 400-year term is 0
  assign k_base = 9'(y5[9:2]) + 9'd7 - 9'(year_offset_i >= 7'd100);
  assign k_mar  = k_base + MarShift;
  assign k_oct  = k_base + OctShift;

  assign last_sun_mar = 5'd31 - 5'(mod7(17'(k_mar)));
  assign last_sun_oct = 5'd31 - 5'(mod7(17'(k_oct)));

  always_comb begin
    priority if (month_i > MonthMar && month_i < MonthOct) begin
      summer_time_o = 1'b1;
    end else if (month_i == MonthMar) begin
      summer_time_o = (day_i >= last_sun_mar);
    end else if (month_i == MonthOct) begin
      summer_time_o = (day_i <= last_sun_oct);
    end else begin
      summer_time_o = 1'b0;
    end
  end

endmodule

### design/calendar_day_count_weekday_dst.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// request   in         start & !busy             year_offset_i, month_i, day_i
// result    out        result_valid_o (1 cycle)  day_count_o, weekday_o, summer_time_o
//
// one request per cycle; an accepted request goes through the request register
// and then the result register, around one pass of date arithmetic
// busy stays low, so every request with start high is taken
// rst_ni clears only the valid flags, payload registers are not reset
// results are shown for one cycle and the receiver cannot stall them

module calendar_day_count_weekday_dst
  import cdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [YearW-1:0]  year_offset_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [DayW-1:0]   day_i,
  output logic              result_valid_o,
  output logic [CountW-1:0] day_count_o,
  output logic [WdayW-1:0]  weekday_o,
  output logic              summer_time_o
);

  // request register
  logic              req_vld_q;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   day_q;

  // combinational results
  logic [CountW-1:0] day_count_d;
  logic [WdayW-1:0]  weekday_d;
  logic              summer_d;

  // result register
  logic              res_vld_q;
  logic [CountW-1:0] day_count_q;
  logic [WdayW-1:0]  weekday_q;
  logic              summer_q;

  // pipeline never holds back
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
      res_vld_q <= req_vld_q;
    end
  end

  // payload captured without reset, qualified by the valid flags
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      year_q  <= year_offset_i;
      month_q <= month_i;
      day_q   <= day_i;
    end
    if (req_vld_q) begin
      day_count_q <= day_count_d;
      weekday_q   <= weekday_d;
      summer_q    <= summer_d;
    end
  end

  // day count and weekday
  cdc_day_count u_day_count (
    .year_offset_i (year_q),
    .month_i       (month_q),
    .day_i         (day_q),
    .day_count_o   (day_count_d),
    .weekday_o     (weekday_d)
  );

  // european summer time flag
  cdc_dst u_dst (
    .year_offset_i (year_q),
    .month_i       (month_q),
    .day_i         (day_q),
    .summer_time_o (summer_d)
  );

  assign result_valid_o = res_vld_q;
  assign day_count_o    = day_count_q;
  assign weekday_o      = weekday_q;
  assign summer_time_o  = summer_q;

endmodule
